>>> hw/rtl/cidt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked id table package
// Sizes, operation and status codes, and the structs shared by the table's
// directory, slot memory and top level.
// ----------------------------------------------------------------------------
package cidt_pkg;

   localparam int SLOTS_PER_CHUNK = 16;
   localparam int MAX_CHUNKS      = 8;
   localparam int ID_W            = 32;
   localparam int VAL_W           = 32;
   localparam int OFF_W           = $clog2(SLOTS_PER_CHUNK);
   localparam int BLK_W           = ID_W - OFF_W;
   localparam int CHUNK_W         = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int CNT_W           = $clog2(MAX_CHUNKS + 1);
   localparam int ADDR_W          = CHUNK_W + OFF_W;
   localparam int SLOTS_TOTAL     = MAX_CHUNKS * SLOTS_PER_CHUNK;

   typedef enum logic [1:0] {
      OP_GET      = 2'd0,
      OP_ADD      = 2'd1,
      OP_REMOVE   = 2'd2,
      OP_ADD_AUTO = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE        = 2'd0,
      ST_NOT_COVERED = 2'd1,
      ST_NO_SPACE    = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [ID_W-1:0]    item_id;
      logic [VAL_W-1:0]   item_value;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0]   read_value;
      logic [ID_W-1:0]    assigned_id;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic               hit;
      logic [CHUNK_W-1:0] hit_chunk;
      logic               hit_occ;
      logic               free_found;
      logic [CHUNK_W-1:0] free_chunk;
      logic [OFF_W-1:0]   free_slot;
      logic [BLK_W-1:0]   free_blk;
      logic               full;
      logic [CHUNK_W-1:0] next_chunk;
   } lookup_type;

   typedef struct packed {
      logic               occ_we;
      logic               alloc;
      logic [CHUNK_W-1:0] chunk;
      logic [OFF_W-1:0]   slot;
      logic               occ_set;
      logic [BLK_W-1:0]   blk;
   } update_type;

   typedef struct packed {
      logic               we;
      logic               re;
      logic [ADDR_W-1:0]  addr;
      logic [VAL_W-1:0]   wdata;
   } mem_cmd_type;

endpackage

>>> hw/rtl/cidt_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked id table slot memory
// One synchronous single-port store of slot values, one entry per slot of
// every chunk, with a registered read port. Entries are qualified by the
// occupancy bits of the directory, so the array needs no clearing.
// ----------------------------------------------------------------------------
module cidt_slot_mem (
   input  logic                       clock,
   input  cidt_pkg::mem_cmd_type      cmd,
   output logic [cidt_pkg::VAL_W-1:0] rdata
);

   logic [cidt_pkg::VAL_W-1:0] mem [cidt_pkg::SLOTS_TOTAL];
   logic [cidt_pkg::VAL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.re) begin
         rdata_ff <= mem[cmd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/cidt_dir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked id table directory
// Chunk tags, chunk count and per-slot occupancy flags in flops. Matches an
// id's block against all tags, finds the first free slot in allocation
// order, and applies the slot and chunk updates chosen by the top level.
// ----------------------------------------------------------------------------
module cidt_dir (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [cidt_pkg::ID_W-1:0] req_id,
   input  cidt_pkg::update_type      upd,
   output cidt_pkg::lookup_type      lk
);

   logic [cidt_pkg::BLK_W-1:0]           blk_ff [cidt_pkg::MAX_CHUNKS];
   logic [cidt_pkg::SLOTS_PER_CHUNK-1:0] occ_ff [cidt_pkg::MAX_CHUNKS];
   logic [cidt_pkg::CNT_W-1:0]           count_ff;
   logic [cidt_pkg::CNT_W-1:0]           count_in;

   logic [cidt_pkg::MAX_CHUNKS-1:0]      chunk_on;
   logic [cidt_pkg::MAX_CHUNKS-1:0]      hit_vec;
   logic [cidt_pkg::MAX_CHUNKS-1:0]      free_vec;
   logic [cidt_pkg::MAX_CHUNKS-1:0]      free_sel;
   logic [cidt_pkg::SLOTS_PER_CHUNK-1:0] free_row;
   logic [cidt_pkg::SLOTS_PER_CHUNK-1:0] alloc_row;
   logic [cidt_pkg::BLK_W-1:0]           req_blk;
   logic [cidt_pkg::OFF_W-1:0]           req_off;

   assign req_blk = req_id[cidt_pkg::ID_W-1:cidt_pkg::OFF_W];
   assign req_off = req_id[cidt_pkg::OFF_W-1:0];

   always_comb begin
      lk       = '0;
      free_sel = '0;
      free_row = '0;
      for (int k = 0; k < cidt_pkg::MAX_CHUNKS; k++) begin
         chunk_on[k] = cidt_pkg::CNT_W'(k) < count_ff;
         hit_vec[k]  = chunk_on[k] && (blk_ff[k] == req_blk);
         free_vec[k] = chunk_on[k] && !(&occ_ff[k]);
      end
      for (int k = 0; k < cidt_pkg::MAX_CHUNKS; k++) begin
         if (hit_vec[k]) begin
            lk.hit       = 1'b1;
            lk.hit_chunk = cidt_pkg::CHUNK_W'(k);
            lk.hit_occ   = occ_ff[k][req_off];
         end
      end
      for (int k = cidt_pkg::MAX_CHUNKS - 1; k >= 0; k--) begin
         if (free_vec[k]) begin
            lk.free_found = 1'b1;
            lk.free_chunk = cidt_pkg::CHUNK_W'(k);
            free_sel      = '0;
            free_sel[k]   = 1'b1;
         end
      end
      for (int k = 0; k < cidt_pkg::MAX_CHUNKS; k++) begin
         if (free_sel[k]) begin
            free_row    = free_row | occ_ff[k];
            lk.free_blk = lk.free_blk | blk_ff[k];
         end
      end
      for (int i = cidt_pkg::SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
         if (!free_row[i]) begin
            lk.free_slot = cidt_pkg::OFF_W'(i);
         end
      end
      lk.full       = count_ff == cidt_pkg::CNT_W'(cidt_pkg::MAX_CHUNKS);
      lk.next_chunk = count_ff[cidt_pkg::CHUNK_W-1:0];
   end

   always_comb begin
      alloc_row           = '0;
      alloc_row[upd.slot] = upd.occ_set;
      count_in            = count_ff + cidt_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= cidt_pkg::CNT_W'(1);
         for (int k = 0; k < cidt_pkg::MAX_CHUNKS; k++) begin
            blk_ff[k] <= '0;
            occ_ff[k] <= '0;
         end
      end else begin
         if (upd.alloc) begin
            blk_ff[upd.chunk] <= upd.blk;
            occ_ff[upd.chunk] <= alloc_row;
            count_ff          <= count_in;
         end else if (upd.occ_we) begin
            occ_ff[upd.chunk][upd.slot] <= upd.occ_set;
         end
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= cidt_pkg::CNT_W'(cidt_pkg::MAX_CHUNKS)))
      else $error("chunk count out of range");

   a_tag_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("block matched by more than one chunk");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      upd.alloc |-> !lk.full && !lk.hit)
      else $error("chunk allocated while full or already covered");
`endif

endmodule

>>> hw/rtl/chunked_id_table_with_auto_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked id table with automatic id allocation
// Sparse map from 32-bit ids to 32-bit values held in aligned chunks of
// slots, with get, add, remove and add-at-first-free operations.
//
// Usage:
//   req_* carries one operation (opcode, item_id, item_value); rsp_* returns
//   one result (read_value, assigned_id, status) for every operation, in
//   order. A transfer happens when valid is high and stall is low.
//   The directory lookup and free-slot search run in the accept cycle, and
//   the slot memory is read or written at the accept edge. The result is
//   loaded into the output register once that register is free, which
//   raises rsp_valid. One operation is in flight at a time, so the block
//   takes no new request until the last result is in the output register;
//   this is set by the single slot memory port and its registered read.
//   Reset clears the chunk table to one chunk covering ids 0 to 15 with all
//   slots empty, and drops any request or result in flight. No clearing
//   pass is needed; occupancy flags qualify the slot memory.
//   While rsp_stall is high the result holds in the output register; the
//   next request is still taken, and completes once the register frees.
// ----------------------------------------------------------------------------
module chunked_id_table_with_auto_alloc (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cidt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cidt_pkg::rsp_type rsp_data
);

   cidt_pkg::lookup_type       lk;
   cidt_pkg::update_type       upd;
   cidt_pkg::update_type       upd_gated;
   cidt_pkg::mem_cmd_type      cmd;
   cidt_pkg::mem_cmd_type      cmd_gated;
   logic [cidt_pkg::VAL_W-1:0] mem_rdata;
   logic [cidt_pkg::OFF_W-1:0] req_off;
   logic                       req_accept;
   logic                       complete;

   cidt_pkg::status_type       st;
   logic [cidt_pkg::ID_W-1:0]  aid;
   logic                       get_hit;

   logic                       busy_ff;
   logic                       get_ff;
   logic [cidt_pkg::ID_W-1:0]  aid_ff;
   cidt_pkg::status_type       st_ff;
   logic                       rsp_valid_ff;
   cidt_pkg::rsp_type          rsp_data_ff;
   cidt_pkg::rsp_type          rsp_data_in;

   assign req_off    = req_data.item_id[cidt_pkg::OFF_W-1:0];
   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign complete   = busy_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      upd       = '0;
      upd.slot  = req_off;
      upd.blk   = req_data.item_id[cidt_pkg::ID_W-1:cidt_pkg::OFF_W];
      cmd       = '0;
      cmd.wdata = req_data.item_value;
      st        = cidt_pkg::ST_DONE;
      aid       = '0;
      get_hit   = 1'b0;
      unique case (req_data.opcode)
         cidt_pkg::OP_GET: begin
            if (lk.hit) begin
               cmd.re   = 1'b1;
               cmd.addr = {lk.hit_chunk, req_off};
               get_hit  = lk.hit_occ;
            end else begin
               st = cidt_pkg::ST_NOT_COVERED;
            end
         end
         cidt_pkg::OP_ADD: begin
            upd.occ_set = |req_data.item_value;
            if (lk.hit) begin
               cmd.we     = 1'b1;
               cmd.addr   = {lk.hit_chunk, req_off};
               upd.occ_we = 1'b1;
               upd.chunk  = lk.hit_chunk;
            end else if (!lk.full) begin
               cmd.we    = 1'b1;
               cmd.addr  = {lk.next_chunk, req_off};
               upd.alloc = 1'b1;
               upd.chunk = lk.next_chunk;
            end else begin
               st = cidt_pkg::ST_NO_SPACE;
            end
         end
         cidt_pkg::OP_REMOVE: begin
            if (lk.hit) begin
               upd.occ_we = 1'b1;
               upd.chunk  = lk.hit_chunk;
            end else begin
               st = cidt_pkg::ST_NOT_COVERED;
            end
         end
         cidt_pkg::OP_ADD_AUTO: begin
            upd.occ_set = |req_data.item_value;
            if (lk.free_found) begin
               cmd.we     = 1'b1;
               cmd.addr   = {lk.free_chunk, lk.free_slot};
               upd.occ_we = 1'b1;
               upd.chunk  = lk.free_chunk;
               upd.slot   = lk.free_slot;
               aid        = {lk.free_blk, lk.free_slot};
            end else begin
               st = cidt_pkg::ST_NO_SPACE;
            end
         end
      endcase
   end

   always_comb begin
      upd_gated        = upd;
      upd_gated.occ_we = upd.occ_we && req_accept;
      upd_gated.alloc  = upd.alloc && req_accept;
      cmd_gated        = cmd;
      cmd_gated.we     = cmd.we && req_accept;
      cmd_gated.re     = cmd.re && req_accept;
   end

   always_comb begin
      rsp_data_in.read_value  = get_ff ? mem_rdata : '0;
      rsp_data_in.assigned_id = aid_ff;
      rsp_data_in.status      = st_ff;
   end

   cidt_dir u_dir (
      .clock  (clock),
      .reset  (reset),
      .req_id (req_data.item_id),
      .upd    (upd_gated),
      .lk     (lk)
   );

   cidt_slot_mem u_mem (
      .clock (clock),
      .cmd   (cmd_gated),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            busy_ff <= 1'b1;
         end else if (complete) begin
            busy_ff <= 1'b0;
         end
         if (complete) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         get_ff <= get_hit;
         aid_ff <= aid;
         st_ff  <= st;
      end
      if (complete) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> busy_ff)
      else $error("accepted request not held in flight");

   a_complete_out: assert property (@(posedge clock) disable iff (reset)
      complete |=> rsp_valid_ff && !busy_ff)
      else $error("completed request did not reach the output register");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != cidt_pkg::ST_DONE)
      |-> (rsp_data_ff.read_value == '0) && (rsp_data_ff.assigned_id == '0))
      else $error("failed operation returned a value or id");
`endif

endmodule

>>> verif/tb_chunked_id_table_with_auto_alloc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked id table testbench
// Drives get, add, remove and add-at-first-free operations into the table.
// A short directed table comes first: reset contents, field extremes, chunk
// allocation up to a full table, uncovered ids and value zero. Random traffic
// follows in alternating fill and drain windows so that the slot store fills
// up and empties again. Each typed directed row is checked against its fixed
// expectation, every other result against an in-bench copy of the chunk
// directory and slot store. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_chunked_id_table_with_auto_alloc;

   localparam int RANDOM_OPS  = 1330;
   localparam int WINDOW_OPS  = 190;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      cidt_pkg::req_type stim;
      logic              typed;
      cidt_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cidt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cidt_pkg::rsp_type rsp_data;

   int sender_gap_pct     = 21;
   int receiver_stall_pct = 65;
   int error_count        = 0;
   int checked_count      = 0;
   int not_covered_count  = 0;
   int no_space_count     = 0;

   logic [cidt_pkg::BLK_W-1:0] chunk_base [cidt_pkg::MAX_CHUNKS];
   logic [cidt_pkg::VAL_W-1:0] slot_mem   [cidt_pkg::SLOTS_TOTAL];
   int                         chunk_count;

   cidt_pkg::rsp_type expected_results [$];
   cidt_pkg::rsp_type oldest;
   dir_row_type       directed_rows [$];

   chunked_id_table_with_auto_alloc u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic cidt_pkg::rsp_type apply_table_op(input cidt_pkg::req_type r);
      cidt_pkg::rsp_type          res;
      logic [cidt_pkg::BLK_W-1:0] blk;
      int                         off;
      int                         hit;
      int                         k;
      int                         i;
      bit                         placed;
      res        = '0;
      res.status = cidt_pkg::ST_DONE;
      blk        = r.item_id[cidt_pkg::ID_W-1:cidt_pkg::OFF_W];
      off        = int'(r.item_id[cidt_pkg::OFF_W-1:0]);
      hit        = -1;
      placed     = 1'b0;
      for (k = 0; k < chunk_count; k++)
         if (hit < 0 && chunk_base[k] == blk) hit = k;
      case (r.opcode)
         cidt_pkg::OP_GET: begin
            if (hit >= 0) res.read_value = slot_mem[hit*cidt_pkg::SLOTS_PER_CHUNK + off];
            else res.status = cidt_pkg::ST_NOT_COVERED;
         end
         cidt_pkg::OP_ADD: begin
            if (hit >= 0) begin
               slot_mem[hit*cidt_pkg::SLOTS_PER_CHUNK + off] = r.item_value;
            end else if (chunk_count < cidt_pkg::MAX_CHUNKS) begin
               chunk_base[chunk_count] = blk;
               for (i = 0; i < cidt_pkg::SLOTS_PER_CHUNK; i++)
                  slot_mem[chunk_count*cidt_pkg::SLOTS_PER_CHUNK + i] = '0;
               slot_mem[chunk_count*cidt_pkg::SLOTS_PER_CHUNK + off] = r.item_value;
               chunk_count++;
            end else begin
               res.status = cidt_pkg::ST_NO_SPACE;
            end
         end
         cidt_pkg::OP_REMOVE: begin
            if (hit >= 0) slot_mem[hit*cidt_pkg::SLOTS_PER_CHUNK + off] = '0;
            else res.status = cidt_pkg::ST_NOT_COVERED;
         end
         cidt_pkg::OP_ADD_AUTO: begin
            for (k = 0; k < chunk_count; k++)
               for (i = 0; i < cidt_pkg::SLOTS_PER_CHUNK; i++)
                  if (!placed && slot_mem[k*cidt_pkg::SLOTS_PER_CHUNK + i] == '0) begin
                     slot_mem[k*cidt_pkg::SLOTS_PER_CHUNK + i] = r.item_value;
                     res.assigned_id = {chunk_base[k], i[cidt_pkg::OFF_W-1:0]};
                     placed = 1'b1;
                  end
            if (!placed) res.status = cidt_pkg::ST_NO_SPACE;
         end
      endcase
      return res;
   endfunction

   function automatic dir_row_type dir_row(input cidt_pkg::opcode_type op,
                                           input logic [cidt_pkg::ID_W-1:0] id,
                                           input logic [cidt_pkg::VAL_W-1:0] val,
                                           input logic typed,
                                           input logic [cidt_pkg::VAL_W-1:0] rd,
                                           input logic [cidt_pkg::ID_W-1:0] aid,
                                           input cidt_pkg::status_type st);
      dir_row_type row;
      row.stim.opcode       = op;
      row.stim.item_id      = id;
      row.stim.item_value   = val;
      row.typed             = typed;
      row.want.read_value   = rd;
      row.want.assigned_id  = aid;
      row.want.status       = st;
      return row;
   endfunction

   // called at a falling edge; returns at a falling edge after the transfer
   task automatic transfer_req(input cidt_pkg::req_type r, input logic typed,
                               input cidt_pkg::rsp_type want);
      cidt_pkg::rsp_type predicted;
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_table_op(r);
      expected_results.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: read_value %h assigned_id %h status %0d",
                   rsp_data.read_value, rsp_data.assigned_id, rsp_data.status);
            error_count++;
         end else begin
            oldest = expected_results.pop_front();
            checked_count++;
            if (oldest.status == cidt_pkg::ST_NOT_COVERED) not_covered_count++;
            if (oldest.status == cidt_pkg::ST_NO_SPACE) no_space_count++;
            if (rsp_data.read_value !== oldest.read_value) begin
               $error("read_value: expected %h, got %h", oldest.read_value,
                      rsp_data.read_value);
               error_count++;
            end
            if (rsp_data.assigned_id !== oldest.assigned_id) begin
               $error("assigned_id: expected %h, got %h", oldest.assigned_id,
                      rsp_data.assigned_id);
               error_count++;
            end
            if (rsp_data.status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      cidt_pkg::req_type          stim;
      cidt_pkg::opcode_type       op;
      logic [cidt_pkg::OFF_W-1:0] slot_sel;
      int                         n;
      int                         roll;
      bit                         fill_mode;

      for (n = 0; n < cidt_pkg::MAX_CHUNKS; n++) chunk_base[n] = '0;
      for (n = 0; n < cidt_pkg::SLOTS_TOTAL; n++) slot_mem[n] = '0;
      chunk_count = 1;

      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'h0, 32'h1234_5678, 1'b1, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'hFFFF_FFFF, 0, 1'b1, 0, 0,
                                      cidt_pkg::ST_NOT_COVERED));
      directed_rows.push_back(dir_row(cidt_pkg::OP_REMOVE, 32'h1234_5670, 0, 1'b1, 0, 0,
                                      cidt_pkg::ST_NOT_COVERED));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h0, 32'hFFFF_FFFF, 1'b1, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'h0, 0, 1'b1, 32'hFFFF_FFFF, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD_AUTO, 32'hFFFF_FFFF, 32'h5A5A_5A5A,
                                      1'b1, 0, 1, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD_AUTO, 32'h0, 32'h0, 1'b1, 0, 2,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD_AUTO, 32'h0, 32'h1, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h0000_000F, 32'h8000_0000, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'hFFFF_FFF0, 0, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'hFFFF_FFF0, 32'h0, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'hFFFF_FFFF, 0, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_REMOVE, 32'h0, 0, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'h0, 0, 1'b0, 0, 0,
                                      cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h0000_0010, 32'hA5A5_A5A5, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h5555_5555, 32'h5555_5555, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h8000_0000, 32'hFFFF_FFFE, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h0000_0020, 32'h0000_0002, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD, 32'h0000_0100, 32'h1, 1'b1, 0, 0,
                                      cidt_pkg::ST_NO_SPACE));
      directed_rows.push_back(dir_row(cidt_pkg::OP_GET, 32'h0000_0100, 0, 1'b1, 0, 0,
                                      cidt_pkg::ST_NOT_COVERED));
      directed_rows.push_back(dir_row(cidt_pkg::OP_ADD_AUTO, 32'h0, 32'hCAFE_0001, 1'b0,
                                      0, 0, cidt_pkg::ST_DONE));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[n])
         transfer_req(directed_rows[n].stim, directed_rows[n].typed, directed_rows[n].want);

      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n == RANDOM_OPS / 3) begin
            sender_gap_pct     = 65;
            receiver_stall_pct = 21;
         end
         if (n == 2 * RANDOM_OPS / 3) begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         // alternate windows that fill the store and ones that drain it
         fill_mode = ((n / WINDOW_OPS) % 2) == 0;
         roll      = $urandom_range(99);
         if (fill_mode)
            op = (roll < 60) ? cidt_pkg::OP_ADD_AUTO : (roll < 75) ? cidt_pkg::OP_ADD :
                 (roll < 92) ? cidt_pkg::OP_GET : cidt_pkg::OP_REMOVE;
         else
            op = (roll < 45) ? cidt_pkg::OP_REMOVE : (roll < 75) ? cidt_pkg::OP_GET :
                 (roll < 88) ? cidt_pkg::OP_ADD : cidt_pkg::OP_ADD_AUTO;
         stim.opcode = op;
         if (op != cidt_pkg::OP_ADD_AUTO && $urandom_range(99) < 85) begin
            slot_sel     = cidt_pkg::OFF_W'($urandom_range(cidt_pkg::SLOTS_PER_CHUNK - 1));
            stim.item_id = {chunk_base[cidt_pkg::CHUNK_W'($urandom_range(chunk_count - 1))],
                            slot_sel};
         end else begin
            stim.item_id = $urandom;
         end
         roll = $urandom_range(99);
         if (roll < 6) stim.item_value = '0;
         else if (roll < 10) stim.item_value = '1;
         else stim.item_value = $urandom;
         transfer_req(stim, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Checked %0d transfers (%0d directed): %0d not covered, %0d no space.",
               checked_count, directed_rows.size(), not_covered_count, no_space_count);
      $display("Chunks in use at end: %0d of %0d.", chunk_count, cidt_pkg::MAX_CHUNKS);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> chunked_id_table_with_auto_alloc.f
hw/rtl/cidt_pkg.sv
hw/rtl/cidt_slot_mem.sv
hw/rtl/cidt_dir.sv
hw/rtl/chunked_id_table_with_auto_alloc.sv
verif/tb_chunked_id_table_with_auto_alloc.sv
